>>> src/tftr_pkg.sv
// Shared types, codon constants and the amino-acid letter table of the codon translator.
package tftr_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [6:0] CODON_START = 7'd14;
    localparam logic [6:0] CODON_TAA   = 7'd48;
    localparam logic [6:0] CODON_TAG   = 7'd50;
    localparam logic [6:0] CODON_TGA   = 7'd56;
    localparam logic [6:0] CODON_AMBIG = 7'd64;

    localparam logic [2:0] AMBIG_MARK  = 3'd4;
    localparam logic [1:0] LAST_FRAME  = 2'd2;
    localparam logic [6:0] CHAR_STOP   = 7'h2A;
    localparam logic [6:0] CHAR_AMBIG  = 7'h78;

    // Standard genetic code, indexed by first base * 16 + second * 4 + third.
    localparam logic [0:63][7:0] LETTER_TABLE =
        "knknttttrsrsiimiqhqhpppprrrrllllededaaaaggggvvvv*y*yssss*cwclflf";

    // One decoded codon on its way from the front end to the result sequencer.
    typedef struct packed {
        logic [6:0] codon;
        logic       stopped;
        logic [1:0] frame;
        logic       last;
    } t_job;

    function automatic logic [6:0] letter_of(input logic [6:0] codon);
        logic [7:0] entry;
        entry = LETTER_TABLE[codon[5:0]];
        if (codon[6]) begin
            return CHAR_AMBIG;
        end
        return entry[6:0];
    endfunction

endpackage

>>> src/tftr_if.sv
// Valid/ready channel interfaces for bases, amino-acid results and the configuration write.
interface tftr_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_code;
    logic       last_base;

    modport source (output valid, output base_code, output last_base, input ready);
    modport sink   (input valid, input base_code, input last_base, output ready);
endinterface

interface tftr_amino_if;
    logic       valid;
    logic       ready;
    logic [6:0] amino_char;
    logic [1:0] frame_index;
    logic       last_of_run;

    modport source (output valid, output amino_char, output frame_index,
                    output last_of_run, input ready);
    modport sink   (input valid, input amino_char, input frame_index,
                    input last_of_run, output ready);
endinterface

interface tftr_cfg_if;
    logic valid;
    logic ready;
    logic complement_mode;

    modport source (output valid, output complement_mode, input ready);
    modport sink   (input valid, input complement_mode, output ready);
endinterface

>>> src/tftr_front.sv
// Front end: takes bases, forms codons, tracks the per-frame stop flags and issues jobs.
module tftr_front
    import tftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_complement,
    input  logic       i_accept,
    input  logic [7:0] i_base_code,
    input  logic       i_last_base,
    output logic       o_push,
    output t_job       o_job
);

    logic [2:0] r_hist0, r_hist1, n_hist0, n_hist1;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_seen, n_seen;
    logic [2:0] r_stopped, n_stopped;

    logic [2:0] base;
    logic [1:0] frame;
    logic       ambig;
    logic [6:0] codon;
    logic       stop_next;

    always_comb begin
        if (i_base_code > 8'd3) begin
            base = AMBIG_MARK;
        end else if (i_complement) begin
            base = {1'b0, ~i_base_code[1:0]};
        end else begin
            base = {1'b0, i_base_code[1:0]};
        end
        frame = (r_phase == LAST_FRAME) ? 2'd0 : r_phase + 2'd1;
        ambig = base[2] | r_hist0[2] | r_hist1[2];
        codon = ambig ? CODON_AMBIG : {1'b0, r_hist1[1:0], r_hist0[1:0], base[1:0]};
        if (codon == CODON_START) begin
            stop_next = 1'b0;
        end else if (codon == CODON_TAA || codon == CODON_TAG || codon == CODON_TGA) begin
            stop_next = 1'b1;
        end else begin
            stop_next = r_stopped[frame];
        end
    end

    // A result appears once two earlier bases of the sequence are held.
    assign o_push = i_accept && r_seen[1];
    assign o_job  = '{codon: codon, stopped: stop_next, frame: frame, last: i_last_base};

    always_comb begin
        n_hist0   = r_hist0;
        n_hist1   = r_hist1;
        n_phase   = r_phase;
        n_seen    = r_seen;
        n_stopped = r_stopped;
        if (i_accept) begin
            if (i_last_base) begin
                n_hist0   = '0;
                n_hist1   = '0;
                n_phase   = '0;
                n_seen    = '0;
                n_stopped = '0;
            end else begin
                n_hist1 = r_hist0;
                n_hist0 = base;
                n_phase = frame;
                if (r_seen != 2'd3) begin
                    n_seen = r_seen + 2'd1;
                end
                if (r_seen[1]) begin
                    n_stopped[frame] = stop_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist0   <= '0;
            r_hist1   <= '0;
            r_phase   <= '0;
            r_seen    <= '0;
            r_stopped <= '0;
        end else begin
            r_hist0   <= n_hist0;
            r_hist1   <= n_hist1;
            r_phase   <= n_phase;
            r_seen    <= n_seen;
            r_stopped <= n_stopped;
        end
    end

endmodule

>>> src/tftr_queue.sv
// Short job queue that decouples the front end from the result sequencer.
module tftr_queue
    import tftr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> src/tftr_back.sv
// Result sequencer: looks up each letter and emits it, followed by any end-of-sequence pads.
module tftr_back
    import tftr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [6:0] o_amino_char,
    output logic [1:0] o_frame_index,
    output logic       o_last_of_run
);

    logic       r_valid;
    logic [6:0] r_char;
    logic [1:0] r_frame;
    logic       r_last;
    logic [1:0] r_sub;

    logic       load;
    logic [1:0] cur_frame;
    logic       job_done;
    logic [6:0] cur_char;

    // The pads of a job cover the frames after its own, up to the last frame.
    assign load      = !i_empty && (!r_valid || i_out_ready);
    assign cur_frame = i_head.frame + r_sub;
    assign job_done  = !i_head.last || (cur_frame == LAST_FRAME);
    assign cur_char  = (r_sub != 2'd0 || i_head.stopped) ? CHAR_STOP
                                                         : letter_of(i_head.codon);
    assign o_pop     = load && job_done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= cur_char;
            r_frame <= cur_frame;
            r_last  <= job_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= job_done ? 2'd0 : r_sub + 2'd1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_amino_char  = r_char;
    assign o_frame_index = r_frame;
    assign o_last_of_run = r_last;

endmodule

>>> src/three_frame_codon_translator.sv
// Top level of the three-frame codon translator.
//
// One base is taken per transfer on i_base, and a base can be taken in every cycle
// while the four-entry job queue has room. From the third base of a sequence on, each
// base yields one amino-acid letter on o_amino, one per cycle from the output register
// while o_amino is ready. The last base of a sequence also yields up to two '*' pads,
// one per cycle under the same condition; the queue absorbs the pad bursts, and the
// input stalls only when the output is held back long enough to fill it. Each result
// is registered in the job queue and then in the output register on its way out. The
// complement mode register is written over i_cfg, which is always ready, and should be
// changed only between sequences while no results are outstanding.
module three_frame_codon_translator
    import tftr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    tftr_cfg_if.sink            i_cfg,
    tftr_base_if.sink           i_base,
    tftr_amino_if.source        o_amino
);

    logic r_complement;
    logic base_accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_job new_job;
    t_job head_job;

    assign i_cfg.ready  = 1'b1;
    assign i_base.ready = !q_full;
    assign base_accept  = i_base.valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complement <= 1'b0;
        end else if (i_cfg.valid) begin
            r_complement <= i_cfg.complement_mode;
        end
    end

    tftr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_complement (r_complement),
        .i_accept     (base_accept),
        .i_base_code  (i_base.base_code),
        .i_last_base  (i_base.last_base),
        .o_push       (push),
        .o_job        (new_job)
    );

    tftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (new_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    tftr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .o_pop         (pop),
        .i_out_ready   (o_amino.ready),
        .o_out_valid   (o_amino.valid),
        .o_amino_char  (o_amino.amino_char),
        .o_frame_index (o_amino.frame_index),
        .o_last_of_run (o_amino.last_of_run)
    );

    // A job leaves the queue only when it is there.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("job popped from an empty queue");

    // While a pad burst is under way its job must still sit at the head of the queue.
    a_burst_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_amino.valid && !o_amino.last_of_run) |-> !q_empty)
        else $error("pad burst in progress without its job");

    // A pad always follows a result of the preceding frame.
    a_pad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_amino.valid && o_amino.ready && !o_amino.last_of_run)
            |=> (!o_amino.valid || o_amino.frame_index == $past(o_amino.frame_index) + 2'd1))
        else $error("pad emitted out of frame order");

    // Frame index three is never produced.
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_amino.valid |-> (o_amino.frame_index != 2'd3))
        else $error("frame index out of range");

endmodule

>>> sim/three_frame_codon_translator_tb.sv
// Self-checking testbench for the three-frame codon translator.
module three_frame_codon_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codons packed as first base * 16 + second * 4 + third, with bit 6 marking ambiguity.
    localparam logic [6:0] CODON_ATG     = 7'd14;
    localparam logic [6:0] CODON_TAA     = 7'd48;
    localparam logic [6:0] CODON_TAG     = 7'd50;
    localparam logic [6:0] CODON_TGA     = 7'd56;
    localparam logic [6:0] CODON_UNKNOWN = 7'd64;

    localparam logic [2:0] BASE_UNKNOWN  = 3'd4;
    localparam logic [6:0] CHAR_STOP     = 7'h2A;
    localparam logic [6:0] CHAR_UNKNOWN  = 7'h78;

    localparam logic [7:0] NT_A     = 8'd0;
    localparam logic [7:0] NT_C     = 8'd1;
    localparam logic [7:0] NT_G     = 8'd2;
    localparam logic [7:0] NT_T     = 8'd3;
    localparam logic [7:0] NT_N_LOW = 8'd4;
    localparam logic [7:0] NT_N_MID = 8'd128;
    localparam logic [7:0] NT_N_MAX = 8'd255;

    typedef struct packed {
        logic [6:0] amino;
        logic [1:0] frame;
        logic       last;
    } amino_t;

    class amino_scoreboard;
        amino_t      letters_due[$];
        logic        complement;
        logic [2:0]  prev_base;
        logic [2:0]  older_base;
        logic [1:0]  next_phase;
        logic [1:0]  bases_in_seq;
        logic [2:0]  frame_stopped;
        int unsigned bases_noted;
        int unsigned letters_checked;
        int unsigned mismatches;
        string       code_table;

        function new();
            code_table = "knknttttrsrsiimiqhqhpppprrrrllllededaaaaggggvvvv*y*yssss*cwclflf";
            complement = 1'b0;
            bases_noted = 0;
            letters_checked = 0;
            mismatches = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            prev_base = '0;
            older_base = '0;
            next_phase = '0;
            bases_in_seq = '0;
            frame_stopped = '0;
        endfunction

        function int unsigned outstanding();
            return letters_due.size();
        endfunction

        function void note_letter(input amino_t item);
            letters_due.insert(letters_due.size(), item);
        endfunction

        // Works out the letters caused by one accepted base and queues them in order.
        function void translate_base(input logic [7:0] code, input logic last);
            logic [2:0] b;
            logic [6:0] codon;
            logic [1:0] frame;
            logic [6:0] ch;
            byte        entry;
            int         n;
            amino_t     tail;
            n = 0;
            frame = 2'd0;
            bases_noted++;
            if (code > NT_T) begin
                b = BASE_UNKNOWN;
            end else if (complement) begin
                b = {1'b0, ~code[1:0]};
            end else begin
                b = code[2:0];
            end

            if (bases_in_seq >= 2'd2) begin
                frame = (next_phase == 2'd2) ? 2'd0 : next_phase + 2'd1;
                if (b[2] || prev_base[2] || older_base[2]) begin
                    codon = CODON_UNKNOWN;
                end else begin
                    codon = {1'b0, older_base[1:0], prev_base[1:0], b[1:0]};
                end
                if (codon == CODON_ATG) begin
                    frame_stopped[frame] = 1'b0;
                end else if (codon == CODON_TAA || codon == CODON_TAG || codon == CODON_TGA) begin
                    frame_stopped[frame] = 1'b1;
                end
                if (frame_stopped[frame]) begin
                    ch = CHAR_STOP;
                end else if (codon == CODON_UNKNOWN) begin
                    ch = CHAR_UNKNOWN;
                end else begin
                    entry = code_table[codon[5:0]];
                    ch = entry[6:0];
                end
                note_letter('{ch, frame, 1'b0});
                n++;
            end

            older_base = prev_base;
            prev_base = b;
            if (bases_in_seq != 2'd3) begin
                bases_in_seq = bases_in_seq + 2'd1;
            end
            next_phase = (next_phase == 2'd2) ? 2'd0 : next_phase + 2'd1;

            if (last) begin
                // Frames above the one that took the final codon fell one short.
                if (n > 0) begin
                    for (int f = frame + 1; f < 3; f++) begin
                        note_letter('{CHAR_STOP, 2'(f), 1'b0});
                        n++;
                    end
                end
                clear_sequence();
            end

            if (n > 0) begin
                tail = letters_due.pop_back();
                tail.last = 1'b1;
                note_letter(tail);
            end
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task compare_letter(input logic [6:0] amino, input logic [1:0] frame, input logic last);
            amino_t want;
            if (letters_due.size() == 0) begin
                flag_mismatch($sformatf("letter %h frame %0d with nothing due", amino, frame));
                return;
            end
            want = letters_due.pop_front();
            letters_checked++;
            if (amino !== want.amino) begin
                flag_mismatch($sformatf("letter #%0d amino %h, wanted %h",
                                        letters_checked, amino, want.amino));
            end
            if (frame !== want.frame) begin
                flag_mismatch($sformatf("letter #%0d frame %0d, wanted %0d",
                                        letters_checked, frame, want.frame));
            end
            if (last !== want.last) begin
                flag_mismatch($sformatf("letter #%0d last_of_run %b, wanted %b",
                                        letters_checked, last, want.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic letters_ready;
    logic quiet;
    logic cur_mode;
    int   stall_left;
    int   sequences_sent;
    logic [7:0] seq_q[$];

    amino_scoreboard sb = new();

    tftr_cfg_if   cfg_ch();
    tftr_base_if  base_ch();
    tftr_amino_if amino_ch();

    assign amino_ch.ready = letters_ready;

    three_frame_codon_translator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_base  (base_ch),
        .o_amino (amino_ch)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every transfer, and hold ready low in random bursts.
    initial letters_ready = 1'b0;
    initial stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && amino_ch.valid && letters_ready) begin
            sb.compare_letter(amino_ch.amino_char, amino_ch.frame_index, amino_ch.last_of_run);
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            letters_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            letters_ready <= 1'b0;
        end else begin
            letters_ready <= 1'b1;
        end
    end

    task automatic write_complement(input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.complement_mode <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.complement = value;
        cur_mode = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Valid stays high after a transfer unless a gap is drawn, so bases can go back to back.
    task automatic send_base(input logic [7:0] code, input logic last);
        int gap;
        base_ch.valid <= 1'b1;
        base_ch.base_code <= code;
        base_ch.last_base <= last;
        @(posedge i_clk);
        while (!base_ch.ready) @(posedge i_clk);
        sb.translate_base(code, last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            base_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_queued();
        foreach (seq_q[i]) begin
            send_base(seq_q[i], i == seq_q.size() - 1);
        end
        sequences_sent++;
    endtask

    task automatic hold_until_drained();
        base_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Bases of a short sequence cause no letters and may still be in flight; give them time.
    task automatic settle();
        hold_until_drained();
        repeat (12) @(posedge i_clk);
    endtask

    function automatic void add_base(input logic [7:0] code);
        seq_q.insert(seq_q.size(), code);
    endfunction

    // Mostly clean bases with start and stop codons mixed in; a few noisy or short runs.
    task automatic build_sequence();
        int len;
        int kind;
        logic noisy;
        logic [6:0] motif;
        logic [1:0] eb;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, 2);
        end else if (kind == 1) begin
            len = $urandom_range(25, 60);
        end else begin
            len = $urandom_range(3, 24);
        end
        noisy = ($urandom_range(0, 7) == 0);
        seq_q.delete();
        while (seq_q.size() < len) begin
            kind = $urandom_range(0, 19);
            if (noisy) begin
                add_base(8'($urandom_range(0, 255)));
            end else if (kind == 0) begin
                add_base(8'($urandom_range(4, 255)));
            end else if (kind <= 2) begin
                case ($urandom_range(0, 3))
                    0: motif = CODON_ATG;
                    1: motif = CODON_TAA;
                    2: motif = CODON_TAG;
                    default: motif = CODON_TGA;
                endcase
                for (int k = 2; k >= 0; k--) begin
                    eb = motif[2*k +: 2];
                    add_base({6'd0, cur_mode ? ~eb : eb});
                end
            end else begin
                add_base(8'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic run_random(input int target, input logic pause_once);
        int sent;
        int seqs;
        sent = 0;
        seqs = 0;
        while (sent < target) begin
            build_sequence();
            send_queued();
            sent += seq_q.size();
            seqs++;
            if (pause_once && seqs == 4) begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.complement_mode <= 1'b0;
        base_ch.valid <= 1'b0;
        base_ch.base_code <= '0;
        base_ch.last_base <= 1'b0;
        quiet = 1'b0;
        cur_mode = 1'b0;
        sequences_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_complement(1'b0);

        // Sequences too short to yield any letter.
        seq_q = '{NT_A};
        send_queued();
        seq_q = '{NT_T, NT_N_MAX};
        send_queued();
        // Start and stop codons; length leaves one frame short.
        seq_q = '{NT_A, NT_T, NT_G, NT_T, NT_A, NT_A, NT_C, NT_A, NT_T, NT_G};
        send_queued();
        // Ambiguous bases in open frames and in a frame held by a stop.
        seq_q = '{NT_T, NT_G, NT_A, NT_N_LOW, NT_C, NT_C};
        send_queued();
        seq_q = '{NT_N_MAX, NT_T, NT_A, NT_G, NT_N_MID};
        send_queued();
        settle();

        write_complement(1'b1);
        run_random(150, 1'b1);
        settle();

        write_complement(1'b0);
        run_random(150, 1'b0);
        settle();

        // Final stretch runs flat out on both sides.
        write_complement(1'b1);
        quiet = 1'b1;
        run_random(150, 1'b0);

        hold_until_drained();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d bases in %0d sequences, both complement settings.",
                 sb.bases_noted, sequences_sent);
        $display("%0d letters compared, %0d mismatches.", sb.letters_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
src/tftr_pkg.sv
src/tftr_if.sv
src/tftr_front.sv
src/tftr_queue.sv
src/tftr_back.sv
src/three_frame_codon_translator.sv
sim/three_frame_codon_translator_tb.sv
